// ===== hdl/ftda_pkg.sv =====
// ----------------------------------------------------------------------------
// ftda_pkg: shared definitions for the fixed-point to decimal ASCII core
// Field widths, character codes, the divide-by-ten reciprocal and the
// power-of-ten table used by the shared multiplier.
// ----------------------------------------------------------------------------
package ftda_pkg;

  localparam int unsigned INT_BITS  = 31;
  localparam int unsigned FRAC_BITS = 24;
  localparam int unsigned CFG_W     = 4;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned PROD_W    = 2 * WORD_W;

  // digit buffer depth covers the longest integer part
  localparam int unsigned DIG_DEPTH = 10;
  localparam int unsigned DIG_IDX_W = $clog2(DIG_DEPTH);

  localparam logic [CFG_W-1:0]     MAX_FRAC_DIGITS = 4'd8;
  localparam logic [DIG_IDX_W-1:0] MAX_INT_DIGITS  = 4'd10;

  localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CH_SEP  = 8'h70;

  // floor(n / 10) == (n * RECIP10) >> RECIP_SHIFT for every 32-bit n
  localparam logic [WORD_W-1:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int unsigned       RECIP_SHIFT = 35;

  typedef struct packed {
    logic                 we;
    logic [DIG_IDX_W-1:0] addr;
    logic [DIGIT_W-1:0]   data;
  } dig_wr_t;

  function automatic logic [WORD_W-1:0] pow10(input logic [CFG_W-1:0] n);
    logic [WORD_W-1:0] p;
    unique case (n)
      4'd0:    p = 32'd1;
      4'd1:    p = 32'd10;
      4'd2:    p = 32'd100;
      4'd3:    p = 32'd1000;
      4'd4:    p = 32'd10000;
      4'd5:    p = 32'd100000;
      4'd6:    p = 32'd1000000;
      4'd7:    p = 32'd10000000;
      4'd8:    p = 32'd100000000;
      4'd9:    p = 32'd1000000000;
      default: p = 32'd1;
    endcase
    return p;
  endfunction

endpackage

// ===== hdl/ftda_if.sv =====
// ----------------------------------------------------------------------------
// ftda_if: valid/ready channels of the fixed-point to decimal ASCII core
// Input number channel, output character channel and configuration write.
// ----------------------------------------------------------------------------
interface ftda_in_if;
  logic                                valid;
  logic                                ready;
  logic [ftda_pkg::INT_BITS-1:0]       int_part;
  logic [ftda_pkg::FRAC_BITS-1:0]      frac_part;

  modport source (output valid, output int_part, output frac_part, input ready);
  modport sink   (input valid, input int_part, input frac_part, output ready);
endinterface

interface ftda_out_if;
  logic                                valid;
  logic                                ready;
  logic [ftda_pkg::CHAR_W-1:0]         char_code;
  logic                                last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface ftda_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [ftda_pkg::CFG_W-1:0]          data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/ftda_mul.sv =====
// ----------------------------------------------------------------------------
// ftda_mul: shared 32x32 multiplier with registered product
// Serves both the divide-by-ten steps and the fraction scaling.
// ----------------------------------------------------------------------------
module ftda_mul (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [ftda_pkg::WORD_W-1:0]   a_i,
  input  logic [ftda_pkg::WORD_W-1:0]   b_i,
  output logic [ftda_pkg::PROD_W-1:0]   prod_o
);
  import ftda_pkg::*;

  logic [PROD_W-1:0] prod_q;

  // capture the product only when asked, so it holds across stalls
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== hdl/ftda_digit_buf.sv =====
// ----------------------------------------------------------------------------
// ftda_digit_buf: decimal digit store
// Collects digits least significant first and hands them back by index.
// ----------------------------------------------------------------------------
module ftda_digit_buf (
  input  logic                            clk_i,
  input  ftda_pkg::dig_wr_t               wr_i,
  input  logic [ftda_pkg::DIG_IDX_W-1:0]  raddr_i,
  output logic [ftda_pkg::DIGIT_W-1:0]    rdata_o
);
  import ftda_pkg::*;

  logic [DIGIT_W-1:0] dig_q [DIG_DEPTH];

  // store one digit per division step
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      dig_q[wr_i.addr] <= wr_i.data;
    end
  end

  assign rdata_o = dig_q[raddr_i];

endmodule

// ===== hdl/fixed_to_decimal_ascii_core.sv =====
// Per item: each integer digit takes a multiply step and a remainder step,
// then the digits are emitted most significant first; when fraction digits
// follow, a scale step and the separator come next, then the same divide and
// emit steps for the fraction digits. Emits and the separator wait on output stalls.
// One item at a time; a new item is taken once the last character is queued.
// Reset (rst_ni low, asynchronous) empties the output and sets frac_digits to 2.
// ----------------------------------------------------------------------------
// fixed_to_decimal_ascii_core: fixed-point number to decimal ASCII text
// Sequencer around a shared multiplier and a small digit store.
// ----------------------------------------------------------------------------
module fixed_to_decimal_ascii_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  ftda_in_if.sink         in_i,
  ftda_out_if.source      out_o,
  ftda_cfg_if.sink        cfg_i
);
  import ftda_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_REM   = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_SCALE = 3'd4;
  localparam logic [2:0] S_SEP   = 3'd5;

  // control state
  logic [2:0]           state_q, state_d;
  logic                 out_valid_q, out_valid_d;
  logic [CFG_W-1:0]     frac_digits_q;

  // payload state
  logic [WORD_W-1:0]    v_q, v_d;
  logic [FRAC_BITS-1:0] frac_q, frac_d;
  logic [CFG_W-1:0]     count_q, count_d;
  logic                 has_frac_q, has_frac_d;
  logic                 frac_phase_q, frac_phase_d;
  logic [DIG_IDX_W-1:0] nd_q, nd_d;
  logic [DIG_IDX_W-1:0] idx_q, idx_d;
  logic [CHAR_W-1:0]    char_q, char_d;
  logic                 last_q, last_d;

  logic                 mul_en;
  logic [WORD_W-1:0]    mul_a, mul_b;
  logic [PROD_W-1:0]    prod;
  logic [WORD_W-1:0]    quot;
  logic [WORD_W-1:0]    rem_w;
  logic [DIG_IDX_W-1:0] nd_inc;
  logic                 div_done;
  logic                 slot_free;
  logic                 in_take;
  logic [CFG_W-1:0]     count_sat;
  dig_wr_t              dig_wr;
  logic [DIGIT_W-1:0]   dig_rd;

  ftda_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  ftda_digit_buf u_dig (
    .clk_i   (clk_i),
    .wr_i    (dig_wr),
    .raddr_i (idx_q),
    .rdata_o (dig_rd)
  );

  // configuration port is always open
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_digits_q <= 4'd2;
    end else if (cfg_i.valid) begin
      frac_digits_q <= cfg_i.data;
    end
  end

  // handshake helpers
  assign in_i.ready = (state_q == S_IDLE);
  assign in_take    = in_i.valid && (state_q == S_IDLE);
  assign slot_free  = !out_valid_q || out_o.ready;
  assign count_sat  = (frac_digits_q > MAX_FRAC_DIGITS) ? MAX_FRAC_DIGITS : frac_digits_q;

  // divide-by-ten result and remainder
  assign quot     = WORD_W'(prod[PROD_W-1:RECIP_SHIFT]);
  assign rem_w    = v_q - ((quot << 3) + (quot << 1));
  assign nd_inc   = nd_q + DIG_IDX_W'(1);
  assign div_done = frac_phase_q ? (nd_inc == DIG_IDX_W'(count_q))
                                 : ((quot == '0) || (nd_inc == MAX_INT_DIGITS));

  // share the multiplier between scaling and division
  always_comb begin
    mul_en = (state_q == S_MUL) || (state_q == S_SCALE);
    if (state_q == S_SCALE) begin
      mul_a = WORD_W'(frac_q);
      mul_b = pow10(count_q);
    end else begin
      mul_a = v_q;
      mul_b = RECIP10;
    end
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    v_d          = v_q;
    frac_d       = frac_q;
    count_d      = count_q;
    has_frac_d   = has_frac_q;
    frac_phase_d = frac_phase_q;
    nd_d         = nd_q;
    idx_d        = idx_q;
    char_d       = char_q;
    last_d       = last_q;
    dig_wr.we    = 1'b0;
    dig_wr.addr  = nd_q;
    dig_wr.data  = rem_w[DIGIT_W-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_take) begin
          v_d          = WORD_W'(in_i.int_part);
          frac_d       = in_i.frac_part;
          count_d      = count_sat;
          has_frac_d   = (count_sat != '0) && (in_i.frac_part != '0);
          frac_phase_d = 1'b0;
          nd_d         = '0;
          state_d      = S_MUL;
        end
      end
      S_MUL: begin
        state_d = S_REM;
      end
      S_REM: begin
        dig_wr.we = 1'b1;
        v_d       = quot;
        nd_d      = nd_inc;
        if (div_done) begin
          idx_d   = nd_q;
          state_d = S_EMIT;
        end else begin
          state_d = S_MUL;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          char_d      = CH_ZERO + CHAR_W'(dig_rd);
          last_d      = (idx_q == '0) && (frac_phase_q || !has_frac_q);
          if (idx_q == '0) begin
            state_d = (!frac_phase_q && has_frac_q) ? S_SCALE : S_IDLE;
          end else begin
            idx_d = idx_q - DIG_IDX_W'(1);
          end
        end
      end
      S_SCALE: begin
        state_d = S_SEP;
      end
      S_SEP: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          char_d       = CH_SEP;
          last_d       = 1'b0;
          v_d          = prod[FRAC_BITS +: WORD_W];
          nd_d         = '0;
          frac_phase_d = 1'b1;
          state_d      = S_MUL;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q          <= v_d;
    frac_q       <= frac_d;
    count_q      <= count_d;
    has_frac_q   <= has_frac_d;
    frac_phase_q <= frac_phase_d;
    nd_q         <= nd_d;
    idx_q        <= idx_d;
    char_q       <= char_d;
    last_q       <= last_d;
  end

  // output register
  assign out_o.valid     = out_valid_q;
  assign out_o.char_code = char_q;
  assign out_o.last_char = last_q;

endmodule

// ===== hdl/ftda_checker.sv =====
// ----------------------------------------------------------------------------
// ftda_checker: port-level checks for the fixed-point to decimal ASCII core
// Watches the handshakes and character stream; bound to the top level.
// ----------------------------------------------------------------------------
module ftda_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [ftda_pkg::CHAR_W-1:0]   char_code_i,
  input  logic                          last_char_i
);
  import ftda_pkg::*;

  // hold a stalled character
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output item dropped while stalled");

  // drop ready once an item is taken
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while converting");

  // emit only digits or the separator
  a_charset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((char_code_i >= CH_ZERO) && (char_code_i <= (CH_ZERO + 8'd9)))
                    || (char_code_i == CH_SEP))
    else $error("bad character code");

  // never end a number on the separator
  a_sep_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (char_code_i == CH_SEP) |-> !last_char_i)
    else $error("separator flagged as last");

endmodule

bind fixed_to_decimal_ascii_core ftda_checker u_ftda_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .char_code_i (out_o.char_code),
  .last_char_i (out_o.last_char)
);

// ===== sim/fixed_to_decimal_ascii_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_to_decimal_ascii_core_tb: self-checking bench for the decimal text core
// Feeds fixed-point numbers through the input channel, predicts the ASCII
// text of each one under the current fraction digit count and checks every
// character and its last flag as it leaves, under four pacing modes.
// ----------------------------------------------------------------------------
module fixed_to_decimal_ascii_core_tb;
  import ftda_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned RAND_PHASES  = 8;
  localparam int unsigned PHASE_ITEMS  = 37;

  typedef struct packed {
    logic [INT_BITS-1:0]  int_part;
    logic [FRAC_BITS-1:0] frac_part;
  } fixed_num_t;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } ascii_char_t;

  logic clk_i;
  logic rst_ni;

  ftda_in_if  in_if ();
  ftda_out_if out_if ();
  ftda_cfg_if cfg_if ();

  fixed_to_decimal_ascii_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  fixed_num_t        number_q[$];
  ascii_char_t       pending_chars[$];
  logic [CFG_W-1:0]  frac_digits_cfg;
  int unsigned       sender_idle_pct;
  int unsigned       recv_stall_pct;
  bit                in_took;
  int unsigned       cycle_cnt;
  int unsigned       fail_cnt;
  int unsigned       numbers_taken;
  int unsigned       chars_checked;
  int unsigned       cfg_writes;

  // Clock: 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint unsigned ten_pow(input int unsigned k);
    longint unsigned p;
    p = 1;
    repeat (k) p = p * 10;
    return p;
  endfunction

  // Predict the text of one number and queue it for the character monitor
  function automatic void render_number(input logic [INT_BITS-1:0] ival,
                                        input logic [FRAC_BITS-1:0] fval,
                                        input logic [CFG_W-1:0] digits_cfg);
    ascii_char_t       txt[$];
    logic [3:0]        digs[12];
    int unsigned       nd;
    int unsigned       count;
    longint unsigned   v;
    longint unsigned   scaled;
    ascii_char_t       c;
    nd = 0;
    v = longint'(ival);
    count = (digits_cfg > MAX_FRAC_DIGITS) ? int'(MAX_FRAC_DIGITS) : int'(digits_cfg);
    // integer digits, least significant first
    do begin
      digs[nd] = 4'(v % 10);
      v = v / 10;
      nd++;
    end while (v != 0);
    for (int k = int'(nd) - 1; k >= 0; k--) begin
      c.code = CH_ZERO + {4'd0, digs[k]};
      c.last = 1'b0;
      txt.push_back(c);
    end
    // separator and fixed-width fraction digits
    if (count != 0 && fval != '0) begin
      scaled = (longint'(fval) * ten_pow(count)) >> FRAC_BITS;
      c.code = CH_SEP;
      c.last = 1'b0;
      txt.push_back(c);
      for (int k = 0; k < int'(count); k++) begin
        digs[k] = 4'(scaled % 10);
        scaled = scaled / 10;
      end
      for (int k = int'(count) - 1; k >= 0; k--) begin
        c.code = CH_ZERO + {4'd0, digs[k]};
        c.last = 1'b0;
        txt.push_back(c);
      end
    end
    txt[txt.size() - 1].last = 1'b1;
    foreach (txt[i]) pending_chars.push_back(txt[i]);
  endfunction

  function automatic void add_number(input logic [INT_BITS-1:0] ival,
                                     input logic [FRAC_BITS-1:0] fval);
    fixed_num_t n;
    n.int_part  = ival;
    n.frac_part = fval;
    number_q.push_back(n);
  endfunction

  // Integer part: mostly a random digit count, plus edges around powers of ten
  function automatic logic [INT_BITS-1:0] pick_int_part();
    int unsigned     sel;
    logic [31:0]     r;
    longint unsigned p;
    sel = $urandom_range(9);
    r = $urandom;
    case (sel)
      0: return '0;
      1: return {INT_BITS{1'b1}};
      2, 3: return r[INT_BITS-1:0];
      4: begin
        p = ten_pow($urandom_range(9));
        if ($urandom_range(1) == 1) p = p - 1;
        return p[INT_BITS-1:0];
      end
      default: begin
        p = ten_pow($urandom_range(1, 9));
        p = longint'(r) % p;
        return p[INT_BITS-1:0];
      end
    endcase
  endfunction

  function automatic logic [FRAC_BITS-1:0] pick_frac_part();
    int unsigned sel;
    logic [31:0] r;
    sel = $urandom_range(9);
    r = $urandom;
    case (sel)
      0, 1: return '0;
      2: return FRAC_BITS'($urandom_range(1, 15));
      3: return {FRAC_BITS{1'b1}};
      default: return r[FRAC_BITS-1:0];
    endcase
  endfunction

  // Write the fraction digit count while the core is idle
  task automatic write_frac_digits(input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.data  = val;
    do @(posedge clk_i); while (!cfg_if.ready);
    frac_digits_cfg = val;
    cfg_writes++;
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // Wait for every queued number to be taken and every character to arrive
  task automatic wait_drained();
    while (number_q.size() != 0 || pending_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_pacing(input int unsigned mode);
    case (mode % 4)
      0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin sender_idle_pct = 66; recv_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  recv_stall_pct = 66; end
      default: begin sender_idle_pct = 32; recv_stall_pct = 32; end
    endcase
  endtask

  // Input driver: hold an item until taken, otherwise offer the next or idle
  always @(negedge clk_i) begin
    if (!(in_if.valid && !in_took)) begin
      if (rst_ni && number_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_if.valid     <= 1'b1;
        in_if.int_part  <= number_q[0].int_part;
        in_if.frac_part <= number_q[0].frac_part;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
    in_took = 1'b0;
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Taken items: predict their text
  always @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      render_number(in_if.int_part, in_if.frac_part, frac_digits_cfg);
      void'(number_q.pop_front());
      in_took = 1'b1;
      numbers_taken++;
    end
  end

  // Character monitor: compare against the oldest expectation
  always @(posedge clk_i) begin
    ascii_char_t want;
    if (out_if.valid && out_if.ready) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected character: char_code %h last_char %b",
               out_if.char_code, out_if.last_char);
        fail_cnt++;
      end else begin
        want = pending_chars.pop_front();
        chars_checked++;
        if (out_if.char_code !== want.code) begin
          $error("char_code mismatch: expected %h actual %h", want.code, out_if.char_code);
          fail_cnt++;
        end
        if (out_if.last_char !== want.last) begin
          $error("last_char mismatch: expected %b actual %b", want.last, out_if.last_char);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d characters still due",
               cycle_cnt, pending_chars.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [CFG_W-1:0] phase_cfg[RAND_PHASES];
    phase_cfg = '{4'd8, 4'd0, 4'd15, 4'd4, 4'd1, 4'd9, 4'd6, 4'd3};
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.int_part  = '0;
    in_if.frac_part = '0;
    out_if.ready    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.data     = '0;
    frac_digits_cfg = 4'd2;
    in_took         = 1'b0;
    cycle_cnt       = 0;
    fail_cnt        = 0;
    numbers_taken   = 0;
    chars_checked   = 0;
    cfg_writes      = 0;
    set_pacing(0);
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset count of two, field extremes, fraction that floors to zero
    add_number('0, '0);
    add_number({INT_BITS{1'b1}}, {FRAC_BITS{1'b1}});
    add_number(31'd1000000000, '0);
    add_number(31'd999999999, 24'd1);
    add_number(31'd5, 24'h800000);
    wait_drained();

    // Zero digit count: fraction ignored
    write_frac_digits(4'd0);
    add_number(31'd123, 24'hABCDEF);
    add_number('0, {FRAC_BITS{1'b1}});
    wait_drained();

    // Widest fraction
    write_frac_digits(4'd8);
    add_number({INT_BITS{1'b1}}, {FRAC_BITS{1'b1}});
    add_number('0, 24'd1);
    add_number(31'd42, 24'h800000);
    wait_drained();

    // Counts above range saturate
    write_frac_digits(4'd15);
    add_number({INT_BITS{1'b1}}, {FRAC_BITS{1'b1}});
    add_number(31'd7, 24'd1);
    wait_drained();
    write_frac_digits(4'd9);
    add_number(31'd10, 24'h555555);
    wait_drained();

    // Single digit, truncation to zero and alternating bit patterns
    write_frac_digits(4'd1);
    add_number(31'd9, 24'd1);
    add_number(31'h55555555, 24'hAAAAAA);
    add_number(31'h2AAAAAAA, 24'h555555);
    add_number(31'd0, 24'hFFFFFF);
    wait_drained();

    // Random phases: one count and one pacing mode each
    for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
      write_frac_digits(phase_cfg[ph]);
      set_pacing(ph);
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        add_number(pick_int_part(), pick_frac_part());
      end
      wait_drained();
    end

    $display("Converted %0d numbers into %0d checked characters", numbers_taken,
             chars_checked);
    $display("across %0d fraction digit writes (0 to 15) and four pacing modes",
             cfg_writes);
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
